FILE: rtl/thrust_aligned_ellipsoid_core_macros.svh
// Assertion macros shared by the ellipsoid core.
`ifndef THRUST_ALIGNED_ELLIPSOID_CORE_MACROS_SVH
`define THRUST_ALIGNED_ELLIPSOID_CORE_MACROS_SVH
// An implication checked on every clock edge outside reset.
`define TAE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// A next-cycle implication checked outside reset.
`define TAE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/tae_pkg.sv
// ---------------------------------------------------------------------------
// Ellipsoid core package
// Types and constants shared by the pipeline modules.
// ---------------------------------------------------------------------------
package tae_pkg;
    localparam int RatioBits = 30;
    localparam int DivSteps  = 31;

    localparam logic [1:0] RegAxisX = 2'd0;
    localparam logic [1:0] RegAxisY = 2'd1;
    localparam logic [1:0] RegAxisZ = 2'd2;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_vec3;
endpackage

FILE: rtl/thrust_aligned_ellipsoid_core.sv
// ---------------------------------------------------------------------------
// Thrust-aligned ellipsoid core
// Shape matrix of an ellipsoid whose third axis follows the thrust vector.
// ---------------------------------------------------------------------------
// One sample enters per cycle while the output transfer is not stalled. The
// pipeline is the 31-stage restoring divider that forms the ratios, plus two
// front-end and four back-end stages. The whole pipeline advances together
// and holds while the output transfer is stalled.
`include "thrust_aligned_ellipsoid_core_macros.svh"
module thrust_aligned_ellipsoid_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_acc_x,
    input  logic signed [31:0] i_acc_y,
    input  logic signed [31:0] i_acc_z,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_shape_xx,
    output logic signed [31:0] o_shape_xy,
    output logic signed [31:0] o_shape_xz,
    output logic signed [31:0] o_shape_yy,
    output logic signed [31:0] o_shape_yz,
    output logic signed [31:0] o_shape_zz,
    output logic signed [31:0] o_center_x,
    output logic signed [31:0] o_center_y,
    output logic signed [31:0] o_center_z,
    output logic        o_degenerate
);
    localparam int Lat = 2 + tae_pkg::DivSteps + 4;

    logic [30:0] r_ax, r_ay, r_az;
    logic [Lat-1:0] r_vld;
    logic w_en;

    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[Lat-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax  <= 31'd65536;
            r_ay  <= 31'd65536;
            r_az  <= 31'd65536;
            r_vld <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tae_pkg::RegAxisX: r_ax <= i_cfg_data;
                    tae_pkg::RegAxisY: r_ay <= i_cfg_data;
                    tae_pkg::RegAxisZ: r_az <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_en) r_vld <= {r_vld[Lat-2:0], i_valid};
        end
    end

    tae_pkg::t_vec3 r_pos [Lat];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pos[0] <= {i_pos_x, i_pos_y, i_pos_z};
            for (int k = 1; k < Lat; k++) r_pos[k] <= r_pos[k-1];
        end
    end

    logic        w_dg;
    logic [30:0] w_num [10];
    logic        w_neg [10];
    logic [31:0] w_n2, w_m2;
    logic signed [32:0] w_q [10];
    logic [tae_pkg::DivSteps-1:0] r_dgd;

    tae_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk(i_clk), .i_en(w_en), .i_acc_x(i_acc_x), .i_acc_y(i_acc_y),
        .i_acc_z(i_acc_z), .o_degen(w_dg), .o_num(w_num), .o_neg(w_neg),
        .o_n2(w_n2), .o_m2(w_m2)
    );

    for (genvar d = 0; d < 10; d++) begin : g_div
        tae_div #(.LAT(tae_pkg::DivSteps)) u_div (
            .i_clk(i_clk), .i_en(w_en), .i_neg(w_neg[d]), .i_num(w_num[d]),
            .i_den(d >= 7 ? w_m2 : w_n2), .o_q(w_q[d])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_dgd <= {r_dgd[tae_pkg::DivSteps-2:0], w_dg};
    end

    logic signed [31:0] w_shape [6];
    tae_back u_back (
        .i_clk(i_clk), .i_en(w_en), .i_ax(r_ax), .i_ay(r_ay), .i_az(r_az),
        .i_q(w_q), .i_degen(r_dgd[tae_pkg::DivSteps-1]), .o_shape(w_shape),
        .o_degen(o_degenerate)
    );

    assign o_shape_xx = w_shape[0];
    assign o_shape_xy = w_shape[1];
    assign o_shape_xz = w_shape[2];
    assign o_shape_yy = w_shape[3];
    assign o_shape_yz = w_shape[4];
    assign o_shape_zz = w_shape[5];
    assign o_center_x = r_pos[Lat-1].x;
    assign o_center_y = r_pos[Lat-1].y;
    assign o_center_z = r_pos[Lat-1].z;

    `TAE_ASSERT_IMP(a_ready_free, i_clk, i_rst_n, !o_valid, o_ready, "ready low with empty output")
    `TAE_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_center_x), "stalled result changed")
    `TAE_ASSERT_IMP(a_degen_zero, i_clk, i_rst_n, o_valid && o_degenerate, o_shape_xx == 32'sd0 && o_shape_zz == 32'sd0, "degenerate result not zeroed")
endmodule

FILE: rtl/tae_div.sv
// ---------------------------------------------------------------------------
// Pipelined ratio divider
// Computes sign * round(|num| * 2^30 / den), one quotient bit per stage.
// ---------------------------------------------------------------------------
module tae_div #(
    parameter int LAT = 31
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic        i_neg,
    input  logic [30:0] i_num,
    input  logic [31:0] i_den,
    output logic signed [32:0] o_q
);
    // Dividend is (num << 30) + den/2; quotient fits 31 bits since num <= den.
    for (genvar s = 0; s < LAT; s++) begin : g_stage
        localparam int B = LAT - 1 - s;
        logic [60:0] w_rem;
        logic [31:0] w_den;
        logic [30:0] w_quo;
        logic        w_neg;
        logic        w_zero;
        logic [92:0] w_sub;
        logic [60:0] n_rem;
        logic        w_ok;
        logic [60:0] r_rem;
        logic [31:0] r_den;
        logic [30:0] r_quo;
        logic        r_neg;
        logic        r_zero;
        if (s == 0) begin : g_first
            assign w_rem  = {i_num, 30'd0} + {29'd0, i_den >> 1};
            assign w_den  = i_den;
            assign w_quo  = '0;
            assign w_neg  = i_neg;
            assign w_zero = (i_den == '0);
        end else begin : g_next
            assign w_rem  = g_stage[s-1].r_rem;
            assign w_den  = g_stage[s-1].r_den;
            assign w_quo  = g_stage[s-1].r_quo;
            assign w_neg  = g_stage[s-1].r_neg;
            assign w_zero = g_stage[s-1].r_zero;
        end
        always_comb begin
            w_sub = {32'd0, w_rem} - ({61'd0, w_den} << B);
            w_ok  = !w_sub[92];
            n_rem = w_ok ? w_sub[60:0] : w_rem;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_rem;
                r_den  <= w_den;
                r_quo  <= w_quo | (31'(w_ok) << B);
                r_neg  <= w_neg;
                r_zero <= w_zero;
            end
        end
    end

    always_comb begin
        if (g_stage[LAT-1].r_zero) begin
            o_q = '0;
        end else if (g_stage[LAT-1].r_neg) begin
            o_q = -$signed({2'b00, g_stage[LAT-1].r_quo});
        end else begin
            o_q = $signed({2'b00, g_stage[LAT-1].r_quo});
        end
    end
endmodule

FILE: rtl/tae_front.sv
// ---------------------------------------------------------------------------
// Ellipsoid front end
// Thrust vector, direction scaling and squared terms, two register stages.
// ---------------------------------------------------------------------------
module tae_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic signed [31:0] i_acc_x,
    input  logic signed [31:0] i_acc_y,
    input  logic signed [31:0] i_acc_z,
    output logic        o_degen,
    output logic [30:0] o_num [10],
    output logic        o_neg [10],
    output logic [31:0] o_n2,
    output logic [31:0] o_m2
);
    localparam logic [39:0] Grav = 40'((((64'd981) << FRAC_BITS) + 64'd50) / 64'd100);

    function automatic logic [5:0] msb_pos(input logic [33:0] v);
        logic [5:0] p;
        p = '0;
        for (int k = 0; k < 34; k++) begin
            if (v[k]) p = 6'(k);
        end
        return p;
    endfunction

    function automatic logic [14:0] shft(input logic [33:0] m, input logic [5:0] p);
        logic [33:0] t;
        if (p >= 6'd14) t = m >> (p - 6'd14);
        else t = m << (6'd14 - p);
        return t[14:0];
    endfunction

    logic [33:0] r_mx, r_my, r_mz;
    logic        r_sx, r_sy, r_sz, r_dg;
    logic signed [33:0] w_vz;

    assign w_vz = 34'(i_acc_z) + $signed({1'b0, Grav[32:0]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mx <= i_acc_x[31] ? 34'(-34'(i_acc_x)) : 34'(i_acc_x);
            r_my <= i_acc_y[31] ? 34'(-34'(i_acc_y)) : 34'(i_acc_y);
            r_mz <= w_vz[33] ? 34'(-w_vz) : 34'(w_vz);
            r_sx <= i_acc_x[31];
            r_sy <= i_acc_y[31];
            r_sz <= w_vz[33];
            r_dg <= (i_acc_y == '0) && (w_vz == '0);
        end
    end

    logic [33:0] w_m3, w_m2;
    logic [5:0]  w_p3, w_p2;
    logic [14:0] w_x, w_y, w_z, w_yp, w_zp;
    always_comb begin
        w_m3 = r_mx | r_my | r_mz;
        w_m2 = r_my | r_mz;
        w_p3 = msb_pos(w_m3);
        w_p2 = msb_pos(w_m2);
        w_x  = shft(r_mx, w_p3);
        w_y  = shft(r_my, w_p3);
        w_z  = shft(r_mz, w_p3);
        w_yp = shft(r_my, w_p2);
        w_zp = shft(r_mz, w_p2);
    end

    logic [29:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_ypyp, r_zpzp, r_ypzp;
    logic        r_s2x, r_s2y, r_s2z, r_s2yp, r_s2zp, r_dg2;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xx   <= 30'(w_x) * 30'(w_x);
            r_yy   <= 30'(w_y) * 30'(w_y);
            r_zz   <= 30'(w_z) * 30'(w_z);
            r_xy   <= 30'(w_x) * 30'(w_y);
            r_xz   <= 30'(w_x) * 30'(w_z);
            r_yz   <= 30'(w_y) * 30'(w_z);
            r_ypyp <= 30'(w_yp) * 30'(w_yp);
            r_zpzp <= 30'(w_zp) * 30'(w_zp);
            r_ypzp <= 30'(w_yp) * 30'(w_zp);
            r_s2x  <= r_sx && (w_x != '0);
            r_s2y  <= r_sy && (w_y != '0);
            r_s2z  <= r_sz && (w_z != '0);
            r_s2yp <= r_sy && (w_yp != '0);
            r_s2zp <= r_sz && (w_zp != '0);
            r_dg2  <= r_dg;
        end
    end

    assign o_degen = r_dg2;
    assign o_n2 = 32'(r_xx) + 32'(r_yy) + 32'(r_zz);
    assign o_m2 = 32'(r_ypyp) + 32'(r_zpzp);
    assign o_num[0] = 31'(r_xx);
    assign o_num[1] = 31'(r_yy);
    assign o_num[2] = 31'(r_zz);
    assign o_num[3] = 31'(r_xy);
    assign o_num[4] = 31'(r_xz);
    assign o_num[5] = 31'(r_yz);
    assign o_num[6] = 31'(r_yy) + 31'(r_zz);
    assign o_num[7] = 31'(r_ypyp);
    assign o_num[8] = 31'(r_zpzp);
    assign o_num[9] = 31'(r_ypzp);
    assign o_neg[0] = 1'b0;
    assign o_neg[1] = 1'b0;
    assign o_neg[2] = 1'b0;
    assign o_neg[3] = (r_s2x ^ r_s2y) && (r_xy != '0);
    assign o_neg[4] = (r_s2x ^ r_s2z) && (r_xz != '0);
    assign o_neg[5] = (r_s2y ^ r_s2z) && (r_yz != '0);
    assign o_neg[6] = 1'b0;
    assign o_neg[7] = 1'b0;
    assign o_neg[8] = 1'b0;
    assign o_neg[9] = (r_s2yp ^ r_s2zp) && (r_ypzp != '0);
endmodule

FILE: rtl/tae_back.sv
// ---------------------------------------------------------------------------
// Ellipsoid back end
// Q30 products, weighted sums, rounding and saturation over four stages.
// ---------------------------------------------------------------------------
module tae_back (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [30:0] i_ax,
    input  logic [30:0] i_ay,
    input  logic [30:0] i_az,
    input  logic signed [32:0] i_q [10],
    input  logic        i_degen,
    output logic signed [31:0] o_shape [6],
    output logic        o_degen
);
    function automatic logic signed [32:0] qmul(input logic signed [32:0] a,
                                                 input logic signed [32:0] b);
        logic [31:0] ma, mb;
        logic [63:0] p;
        logic [33:0] m;
        ma = a[32] ? 32'(-a) : 32'(a);
        mb = b[32] ? 32'(-b) : 32'(b);
        p  = ma * mb;
        m  = 34'((p + 64'(1) * (64'd1 << (tae_pkg::RatioBits - 1))) >> tae_pkg::RatioBits);
        return (a[32] != b[32]) ? -$signed(m[32:0]) : $signed(m[32:0]);
    endfunction

    function automatic logic signed [31:0] fin(input logic signed [66:0] s);
        logic [66:0] ms;
        logic [36:0] m;
        ms = s[66] ? 67'(-s) : 67'(s);
        m  = 37'((ms + (67'd1 << (tae_pkg::RatioBits - 1))) >> tae_pkg::RatioBits);
        if (s[66]) return (m > 37'd2147483648) ? 32'sh80000000 : 32'(-$signed(m));
        return (m > 37'd2147483647) ? 32'sh7fffffff : 32'(m);
    endfunction

    function automatic logic signed [66:0] wm(input logic [30:0] w,
                                              input logic signed [32:0] c);
        return 67'($signed({1'b0, w}) * c);
    endfunction

    logic signed [32:0] r_q [10];
    logic signed [32:0] r_c3, r_c4, r_c5;
    logic        r_d1, r_d2, r_d3;
    logic signed [66:0] r_p [12];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q  <= i_q;
            r_d1 <= i_degen;
            r_c3 <= qmul(r_q[0], r_q[7]);
            r_c4 <= qmul(r_q[0], r_q[9]);
            r_c5 <= qmul(r_q[0], r_q[8]);
            r_d2 <= r_d1;
            r_p[0]  <= wm(i_ax, r_q[6]) + wm(i_az, r_q[0]);
            r_p[1]  <= wm(i_az, r_q[3]) - wm(i_ax, r_q[3]);
            r_p[2]  <= wm(i_az, r_q[4]) - wm(i_ax, r_q[4]);
            r_p[3]  <= wm(i_ay, r_q[8]) + wm(i_az, r_q[1]);
            r_p[4]  <= wm(i_az, r_q[5]) - wm(i_ay, r_q[9]);
            r_p[5]  <= wm(i_ay, r_q[7]) + wm(i_az, r_q[2]);
            r_p[6]  <= r_p[0];
            r_p[7]  <= r_p[1];
            r_p[8]  <= r_p[2];
            r_p[9]  <= r_p[3] + wm(i_ax, r_c3);
            r_p[10] <= r_p[4] + wm(i_ax, r_c4);
            r_p[11] <= r_p[5] + wm(i_ax, r_c5);
            r_d3 <= r_d2;
            for (int k = 0; k < 6; k++) begin
                o_shape[k] <= r_d3 ? 32'sd0 : fin(r_p[6+k]);
            end
            o_degen <= r_d3;
        end
    end
endmodule

FILE: bench/thrust_aligned_ellipsoid_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Thrust-aligned ellipsoid core testbench
// Streams trajectory samples through the core under random gaps and stalls.
// Each result is checked field by field against a fixed-point model of the
// shape matrix, across several settings of the three axis weights.
// ---------------------------------------------------------------------------
module thrust_aligned_ellipsoid_core_tb;

    localparam int           FracBits   = 16;
    localparam int           RatBits    = 30;
    localparam longint       GravQ      = ((64'd981 << FracBits) + 64'd50) / 64'd100;
    localparam int           Latency    = 37;
    localparam longint       CycleLimit = 3000000;
    localparam logic [1:0]   RegUnused  = 2'd3;
    localparam logic [30:0]  AxisMax    = 31'h7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] pos_x, pos_y, pos_z;
        logic signed [31:0] acc_x, acc_y, acc_z;
    } t_sample;

    typedef struct packed {
        logic signed [31:0] xx, xy, xz, yy, yz, zz;
        logic signed [31:0] cx, cy, cz;
        logic               degen;
    } t_shape;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [30:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z, i_acc_x, i_acc_y, i_acc_z;
    logic        o_valid;
    logic        i_ready;
    logic signed [31:0] o_shape_xx, o_shape_xy, o_shape_xz, o_shape_yy, o_shape_yz;
    logic signed [31:0] o_shape_zz, o_center_x, o_center_y, o_center_z;
    logic        o_degenerate;

    longint axis_x, axis_y, axis_z;
    t_shape shape_queue[$];
    int     err_count;
    int     samples_sent;
    int     shapes_seen;
    int     degen_seen;
    longint cycle_count;
    bit     tx_idle_on;
    bit     rx_idle_on;
    bit     hold_req;

    thrust_aligned_ellipsoid_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_acc_x      (i_acc_x),
        .i_acc_y      (i_acc_y),
        .i_acc_z      (i_acc_z),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_shape_xx   (o_shape_xx),
        .o_shape_xy   (o_shape_xy),
        .o_shape_xz   (o_shape_xz),
        .o_shape_yy   (o_shape_yy),
        .o_shape_yz   (o_shape_yz),
        .o_shape_zz   (o_shape_zz),
        .o_center_x   (o_center_x),
        .o_center_y   (o_center_y),
        .o_center_z   (o_center_z),
        .o_degenerate (o_degenerate)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned magnitude(input longint a);
        return a < 0 ? -a : a;
    endfunction

    function automatic longint signed_mag(input longint unsigned m, input bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic void normalise_dir(inout longint a[3], input int cnt);
        longint unsigned mx;
        longint unsigned m;
        int rs;
        int ls;
        mx = 0;
        rs = 0;
        ls = 0;
        for (int i = 0; i < cnt; i++) begin
            if (magnitude(a[i]) > mx) mx = magnitude(a[i]);
        end
        if (mx == 0) return;
        while (mx >= 64'd32768) begin
            mx = mx >> 1;
            rs++;
        end
        while (mx < 64'd16384) begin
            mx = mx << 1;
            ls++;
        end
        for (int i = 0; i < cnt; i++) begin
            m = (magnitude(a[i]) >> rs) << ls;
            a[i] = signed_mag(m, a[i] < 0);
        end
    endfunction

    function automatic longint ratio_q30(input longint num, input longint unsigned den);
        longint unsigned m;
        if (den == 0) return 0;
        m = ((magnitude(num) << RatBits) + (den >> 1)) / den;
        return signed_mag(m, num < 0);
    endfunction

    function automatic longint mul_q30(input longint a, input longint b);
        longint unsigned m;
        m = (magnitude(a) * magnitude(b) + (64'd1 << (RatBits - 1))) >> RatBits;
        return signed_mag(m, (a < 0) != (b < 0));
    endfunction

    function automatic logic [31:0] weigh_entry(input longint c1, input longint c2,
                                                input longint c3);
        longint          s;
        longint unsigned m;
        s = axis_x * c1 + axis_y * c2 + axis_z * c3;
        m = (magnitude(s) + (64'd1 << (RatBits - 1))) >> RatBits;
        if (s < 0) return (m > 64'd2147483648) ? 32'h8000_0000 : 32'(-longint'(m));
        return (m > 64'd2147483647) ? 32'h7FFF_FFFF : 32'(m);
    endfunction

    function automatic t_shape predict_shape(input t_sample s);
        t_shape r;
        longint v[3];
        longint w[3];
        longint unsigned n2, m2;
        longint tx, ty, tz, txy, txz, tyz, ta, py, pz, pyz;
        r = '0;
        r.cx = s.pos_x;
        r.cy = s.pos_y;
        r.cz = s.pos_z;
        v[0] = longint'(s.acc_x);
        v[1] = longint'(s.acc_y);
        v[2] = longint'(s.acc_z) + GravQ;
        if (v[1] == 0 && v[2] == 0) begin
            r.degen = 1'b1;
            return r;
        end
        w[0] = v[1];
        w[1] = v[2];
        w[2] = 0;
        normalise_dir(v, 3);
        normalise_dir(w, 2);
        n2  = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
        m2  = w[0] * w[0] + w[1] * w[1];
        tx  = ratio_q30(v[0] * v[0], n2);
        ty  = ratio_q30(v[1] * v[1], n2);
        tz  = ratio_q30(v[2] * v[2], n2);
        txy = ratio_q30(v[0] * v[1], n2);
        txz = ratio_q30(v[0] * v[2], n2);
        tyz = ratio_q30(v[1] * v[2], n2);
        ta  = ratio_q30(v[1] * v[1] + v[2] * v[2], n2);
        py  = ratio_q30(w[0] * w[0], m2);
        pz  = ratio_q30(w[1] * w[1], m2);
        pyz = ratio_q30(w[0] * w[1], m2);
        r.xx = weigh_entry(ta, 0, tx);
        r.xy = weigh_entry(-txy, 0, txy);
        r.xz = weigh_entry(-txz, 0, txz);
        r.yy = weigh_entry(mul_q30(tx, py), pz, ty);
        r.yz = weigh_entry(mul_q30(tx, pyz), -pyz, tyz);
        r.zz = weigh_entry(mul_q30(tx, pz), py, tz);
        return r;
    endfunction

    task automatic send_sample(input t_sample s);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pos_x <= s.pos_x;
        i_pos_y <= s.pos_y;
        i_pos_z <= s.pos_z;
        i_acc_x <= s.acc_x;
        i_acc_y <= s.acc_y;
        i_acc_z <= s.acc_z;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        shape_queue.insert(shape_queue.size(), predict_shape(s));
        samples_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (shape_queue.size() != 0) @(posedge i_clk);
        repeat (Latency + 8) @(posedge i_clk);
    endtask

    task automatic write_axis(input logic [1:0] idx, input logic [30:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            tae_pkg::RegAxisX: axis_x = longint'(data);
            tae_pkg::RegAxisY: axis_y = longint'(data);
            tae_pkg::RegAxisZ: axis_z = longint'(data);
            default: begin
            end
        endcase
        @(posedge i_clk);
    endtask

    function automatic t_sample rand_sample(input bit realistic);
        t_sample s;
        s.pos_x = $urandom;
        s.pos_y = $urandom;
        s.pos_z = $urandom;
        if (realistic) begin
            s.acc_x = $signed($urandom_range(0, 2 * 1310720)) - 1310720;
            s.acc_y = $signed($urandom_range(0, 2 * 1310720)) - 1310720;
            s.acc_z = $signed($urandom_range(0, 2 * 1310720)) - 1310720;
        end else begin
            s.acc_x = $urandom;
            s.acc_y = $urandom;
            s.acc_z = $urandom;
        end
        case ($urandom_range(0, 19))
            0: begin
                s.acc_y = 0;
                s.acc_z = -32'(GravQ);
            end
            1: s.acc_y = 0;
            2: s.acc_x = 0;
            3: s.acc_z = -32'(GravQ) + $signed($urandom_range(0, 6)) - 3;
            default: begin
            end
        endcase
        return s;
    endfunction

    task automatic test_directed();
        t_sample s;
        logic signed [31:0] ext[4];
        ext[0] = 32'sh8000_0000;
        ext[1] = 32'sh7FFF_FFFF;
        ext[2] = 32'sd0;
        ext[3] = -32'sd1;
        s = '0;
        s.acc_z = -32'(GravQ);
        send_sample(s);
        s.acc_x = 32'sh7FFF_FFFF;
        s.pos_x = 32'sh8000_0000;
        s.pos_y = 32'sh7FFF_FFFF;
        s.pos_z = -32'sd1;
        send_sample(s);
        s.acc_x = 32'sh8000_0000;
        send_sample(s);
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                s.pos_x = ext[j];
                s.pos_y = ext[i];
                s.pos_z = ext[(i + j) % 4];
                s.acc_x = ext[j];
                s.acc_y = ext[i];
                s.acc_z = ext[3 - j];
                send_sample(s);
            end
        end
        s = '0;
        s.acc_z = -32'(GravQ) + 1;
        send_sample(s);
        s.acc_y = 1;
        s.acc_z = -32'(GravQ);
        send_sample(s);
        s = '0;
        send_sample(s);
        wait_drained();
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 200 == 0) begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            send_sample(rand_sample($urandom_range(0, 1)));
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        hold_req   = 1'b1;
        for (int i = 0; i < 100; i++) send_sample(rand_sample(1'b1));
        tx_idle_on = 1'b1;
        wait_drained();
        for (int i = 0; i < 20; i++) send_sample(rand_sample(1'b0));
        wait_drained();
    endtask

    task automatic test_axis_settings();
        write_axis(tae_pkg::RegAxisX, AxisMax);
        write_axis(tae_pkg::RegAxisY, AxisMax);
        write_axis(tae_pkg::RegAxisZ, AxisMax);
        test_directed();
        test_random(200);
        wait_drained();
        write_axis(tae_pkg::RegAxisX, '0);
        write_axis(tae_pkg::RegAxisY, '0);
        write_axis(tae_pkg::RegAxisZ, '0);
        test_random(100);
        wait_drained();
        write_axis(RegUnused, 31'h1234_5678);
        write_axis(tae_pkg::RegAxisX, 31'h0001_8000);
        write_axis(tae_pkg::RegAxisY, AxisMax);
        write_axis(tae_pkg::RegAxisZ, 31'h0000_4000);
        test_directed();
        test_random(200);
        wait_drained();
        for (int k = 0; k < 3; k++) begin
            write_axis(tae_pkg::RegAxisX, 31'($urandom));
            write_axis(tae_pkg::RegAxisY, 31'($urandom_range(0, 1 << 20)));
            write_axis(tae_pkg::RegAxisZ, 31'($urandom));
            test_random(150);
            wait_drained();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_shape e;
        if (i_rst_n && o_valid && i_ready) begin
            if (shape_queue.size() == 0) begin
                $error("result transfer with no sample outstanding");
                err_count++;
            end else begin
                e = shape_queue.pop_front();
                shapes_seen++;
                if (e.degen) degen_seen++;
                check_field("shape_xx", e.xx, o_shape_xx);
                check_field("shape_xy", e.xy, o_shape_xy);
                check_field("shape_xz", e.xz, o_shape_xz);
                check_field("shape_yy", e.yy, o_shape_yy);
                check_field("shape_yz", e.yz, o_shape_yz);
                check_field("shape_zz", e.zz, o_shape_zz);
                check_field("center_x", e.cx, o_center_x);
                check_field("center_y", e.cy, o_center_y);
                check_field("center_z", e.cz, o_center_z);
                check_field("degenerate", 32'(e.degen), 32'(o_degenerate));
            end
        end
    end

    initial begin
        int w;
        i_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                w = rx_idle_on ? $urandom_range(0, 11) : 0;
                if (w > 0) begin
                    i_ready <= 1'b0;
                    repeat (w) @(posedge i_clk);
                end
                i_ready <= 1'b1;
                @(posedge i_clk);
                while (!o_valid) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        cycle_count  = 0;
        err_count    = 0;
        samples_sent = 0;
        shapes_seen  = 0;
        degen_seen   = 0;
        tx_idle_on   = 1'b1;
        rx_idle_on   = 1'b1;
        hold_req     = 1'b0;
        axis_x       = 65536;
        axis_y       = 65536;
        axis_z       = 65536;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_pos_x      = '0;
        i_pos_y      = '0;
        i_pos_z      = '0;
        i_acc_x      = '0;
        i_acc_y      = '0;
        i_acc_z      = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(550);
        wait_drained();
        test_backpressure();
        test_axis_settings();
        wait_drained();
        $display("Sent %0d samples, checked %0d shape results (%0d degenerate).",
                 samples_sent, shapes_seen, degen_seen);
        $display("Covered field extremes, degenerate thrust, stalls and axis weight extremes.");
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/tae_pkg.sv
rtl/tae_div.sv
rtl/tae_front.sv
rtl/tae_back.sv
rtl/thrust_aligned_ellipsoid_core.sv
bench/thrust_aligned_ellipsoid_core_tb.sv
